FILE: sv/cbd_pkg.sv
// Package with shared types, codes and byte classifiers for the chunked body decoder.
`timescale 1ns / 1ps

package cbd_pkg;

  typedef enum logic [2:0] {
    MODE_SKIPWS   = 3'd0,
    MODE_DIGITS   = 3'd1,
    MODE_SKIPLINE = 3'd2,
    MODE_DATA     = 3'd3,
    MODE_TRAILER  = 3'd4,
    MODE_DONE     = 3'd5,
    MODE_ERROR    = 3'd6,
    MODE_TRUNC    = 3'd7
  } mode_t;

  typedef enum logic [2:0] {
    KIND_FRAME    = 3'd0,
    KIND_PAYLOAD  = 3'd1,
    KIND_COMPLETE = 3'd2,
    KIND_ERROR    = 3'd3,
    KIND_TRUNC    = 3'd4,
    KIND_TRAILER  = 3'd5,
    KIND_IGNORED  = 3'd6
  } kind_t;

  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam int         LEN_W   = 32;

  typedef struct packed {
    logic [7:0] out_byte;
    kind_t      kind;
    logic       chunk_last;
  } res_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_t;

  // Space, tab, LF, VT, FF, CR.
  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic hex_t hex_val(input logic [7:0] c);
    hex_t h;
    h.valid = 1'b1;
    h.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.value = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.value = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.value = 4'(c - 8'h37);
    end else begin
      h.valid = 1'b0;
    end
    return h;
  endfunction

endpackage

FILE: sv/cbd_step.sv
// Combinational parse step: next decoder state and result for one byte.
`timescale 1ns / 1ps

module cbd_step
  import cbd_pkg::*;
#(
  parameter int MAX_HEX_DIGITS = 8,
  parameter int CNT_W          = 4
) (
  input  mode_t              mode,
  input  logic [LEN_W-1:0]   remaining,
  input  logic [CNT_W-1:0]   digit_count,
  input  logic               line_has_text,
  input  logic               pass_trailer,
  input  logic [7:0]         in_byte,
  input  logic               end_of_stream,
  output mode_t              mode_next,
  output logic [LEN_W-1:0]   remaining_next,
  output logic [CNT_W-1:0]   digit_count_next,
  output logic               line_has_text_next,
  output res_t               res
);

  hex_t hv;
  logic ws;
  logic too_many;

  assign hv       = hex_val(in_byte);
  assign ws       = is_ws(in_byte);
  assign too_many = (digit_count >= CNT_W'(MAX_HEX_DIGITS))
                  || (remaining[LEN_W-1 -: 4] != 4'd0);

  always_comb begin
    mode_next          = mode;
    remaining_next     = remaining;
    digit_count_next   = digit_count;
    line_has_text_next = line_has_text;
    res.out_byte       = 8'd0;
    res.kind           = KIND_FRAME;
    res.chunk_last     = 1'b0;

    if (mode == MODE_ERROR) begin
      res.kind = KIND_ERROR;
    end else if (mode == MODE_TRUNC) begin
      res.kind = KIND_TRUNC;
    end else if (mode == MODE_DONE) begin
      res.kind = KIND_IGNORED;
    end else if (end_of_stream) begin
      mode_next = MODE_TRUNC;
      res.kind  = KIND_TRUNC;
    end else begin
      case (mode)
        MODE_SKIPWS: begin
          if (ws) begin
            res.kind = KIND_FRAME;
          end else if (hv.valid) begin
            remaining_next   = LEN_W'(hv.value);
            digit_count_next = CNT_W'(1);
            mode_next        = MODE_DIGITS;
          end else begin
            mode_next = MODE_ERROR;
            res.kind  = KIND_ERROR;
          end
        end
        MODE_DIGITS, MODE_SKIPLINE: begin
          if (mode == MODE_DIGITS && hv.valid) begin
            if (too_many) begin
              mode_next = MODE_ERROR;
              res.kind  = KIND_ERROR;
            end else begin
              remaining_next   = {remaining[LEN_W-5:0], hv.value};
              digit_count_next = digit_count + CNT_W'(1);
            end
          end else if (in_byte == CH_LF) begin
            // end of size line
            digit_count_next = '0;
            if (remaining != '0) begin
              mode_next = MODE_DATA;
            end else begin
              mode_next          = MODE_TRAILER;
              line_has_text_next = 1'b0;
            end
          end else if (mode == MODE_DIGITS) begin
            if (ws || in_byte == CH_SEMI) begin
              mode_next = MODE_SKIPLINE;
            end else begin
              mode_next = MODE_ERROR;
              res.kind  = KIND_ERROR;
            end
          end
        end
        MODE_DATA: begin
          res.kind       = KIND_PAYLOAD;
          res.out_byte   = in_byte;
          remaining_next = remaining - LEN_W'(1);
          if (remaining == LEN_W'(1)) begin
            res.chunk_last = 1'b1;
            mode_next      = MODE_SKIPWS;
          end
        end
        default: begin
          // trailer: an LF on an empty line ends the body
          if (!line_has_text && in_byte == CH_LF) begin
            mode_next = MODE_DONE;
            res.kind  = KIND_COMPLETE;
          end else if (!line_has_text && in_byte == CH_CR) begin
            res.kind = KIND_FRAME;
          end else begin
            line_has_text_next = (in_byte != CH_LF);
            if (pass_trailer) begin
              res.kind     = KIND_TRAILER;
              res.out_byte = in_byte;
            end
          end
        end
      endcase
    end
  end

endmodule

FILE: sv/chunked_body_decoder.sv
// Top level of the chunked transfer body decoder with stream ports and output register.
//
//   port group   dir  tdata          tuser     tlast
//   s_axis       in   in_byte        -         end_of_stream
//   m_axis       out  out_byte       kind      chunk_last
//   cfg_we/wdata in   pass_trailer   -         -
//
// One byte per cycle unless m_axis stalls: the parse state and the output register both
// load on each input transfer, so the result is offered on m_axis from the next cycle.
// s_axis_tready stays high while the output register is empty or being drained,
// so a stalled m_axis holds one result and stops further input.
// rst (synchronous) returns to skipping whitespace before a size and clears
// pass_trailer.
`timescale 1ns / 1ps

module chunked_body_decoder
  import cbd_pkg::*;
#(
  parameter int MAX_HEX_DIGITS = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,   // end_of_stream
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic [7:0] m_axis_tuser,   // [2:0] kind
  output logic       m_axis_tlast,   // chunk_last
  input  logic       cfg_we,
  input  logic       cfg_wdata       // pass_trailer
);

  localparam int CNT_W = $clog2(MAX_HEX_DIGITS + 1);

  mode_t            mode, mode_next;
  logic [LEN_W-1:0] remaining, remaining_next;
  logic [CNT_W-1:0] digit_count, digit_count_next;
  logic             line_has_text, line_has_text_next;
  logic             pass_trailer;
  res_t             res_next, res;
  logic             out_valid;
  logic             in_xfer;

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  cbd_step #(
    .MAX_HEX_DIGITS(MAX_HEX_DIGITS),
    .CNT_W         (CNT_W)
  ) u_step (
    .mode              (mode),
    .remaining         (remaining),
    .digit_count       (digit_count),
    .line_has_text     (line_has_text),
    .pass_trailer      (pass_trailer),
    .in_byte           (s_axis_tdata),
    .end_of_stream     (s_axis_tlast),
    .mode_next         (mode_next),
    .remaining_next    (remaining_next),
    .digit_count_next  (digit_count_next),
    .line_has_text_next(line_has_text_next),
    .res               (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_SKIPWS;
      remaining     <= '0;
      digit_count   <= '0;
      line_has_text <= 1'b0;
      pass_trailer  <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        pass_trailer <= cfg_wdata;
      end
      if (in_xfer) begin
        mode          <= mode_next;
        remaining     <= remaining_next;
        digit_count   <= digit_count_next;
        line_has_text <= line_has_text_next;
        out_valid     <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload of the result register, loaded on each input transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res <= res_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = res.out_byte;
  assign m_axis_tuser  = {5'd0, res.kind};
  assign m_axis_tlast  = res.chunk_last;

endmodule
